// ===== hdl/assert_macros.svh =====
// assertion macros used by the job queue of the normalization core
// no dependencies; expands to nothing when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LRN_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LRN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define LRN_ASSERT(lbl, clk, rst_n, prop, msg)
`define LRN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/lrn_pkg.sv =====
// shared types, constants and elaboration-time tables of the normalization core
// no dependencies
package lrn_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int HIST_DEPTH = 16;
	localparam int HIST_AW    = 4;
	localparam int MAX_WINDOW = 15;
	localparam int CNT_W      = 16;
	localparam int SUM_W      = 34;
	localparam int NUM_W      = 69;
	localparam int JOB_DEPTH  = 8;
	localparam int CFG_AW     = 2;
	localparam int CFG_DW     = 32;

	// register indexes
	typedef enum logic [CFG_AW-1:0] {
		REG_WINDOW = 2'd0,
		REG_ALPHA  = 2'd1,
		REG_BETA   = 2'd2,
		REG_BIAS   = 2'd3
	} cfg_reg_t;

	localparam logic [3:0]  WINDOW_RST = 4'd5;
	localparam logic [31:0] ALPHA_RST  = 32'd429497;
	localparam logic [15:0] BETA_RST   = 16'd12288;
	localparam logic [23:0] BIAS_RST   = 24'd131072;

	// one pending output: history slot of its channel, window extent and last flag
	typedef struct packed {
		logic [3:0] slot;
		logic [2:0] below;
		logic [2:0] above;
		logic [3:0] win;
		logic       last;
	} lrn_job_t;

	typedef enum logic {F_IDLE, F_EMIT} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE, B_SUM, B_MUL_LO, B_MUL_HI, B_ADDK, B_ZERO, B_NORM, B_LOG,
		B_DIFF, B_POW, B_SEL, B_EXP, B_SCALE, B_ROUND, B_OUT
	} back_state_t;

	typedef logic [31:0][31:0] root_tab_t;

	// integer square root, bit by bit
	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		int i;
		v = v_in;
		r = '0;
		b = 64'd1 << 62;
		for (i = 0; i < 32; i++) begin
			if (b > v) b = b >> 2;
		end
		for (i = 0; i < 32; i++) begin
			if (b != 64'd0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// successive square roots of two in Q1.31, entry j (1 to 31) is 2^(2^-j), entry 0 is zero
	function automatic root_tab_t exp2_root_table();
		root_tab_t tab;
		logic [63:0] c;
		int j;
		tab = '0;
		c = 64'd1 << 32;
		for (j = 1; j < 32; j++) begin
			c = isqrt64(c << 31);
			tab[j] = c[31:0];
		end
		return tab;
	endfunction

	localparam root_tab_t EXP2_ROOT = exp2_root_table();

endpackage

// ===== hdl/lrn_job_fifo.sv =====
// short queue of pending output jobs between front and back
// depends on lrn_pkg and assert_macros.svh
`include "assert_macros.svh"
module lrn_job_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lrn_pkg::lrn_job_t push_job,
	output logic              full,
	input  logic              pop,
	output lrn_pkg::lrn_job_t pop_job,
	output logic              empty
);
	import lrn_pkg::*;

	localparam int PTR_W = $clog2(JOB_DEPTH);

	lrn_job_t            mem_q [JOB_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [PTR_W:0]      count_q;

	assign full    = (count_q == (PTR_W+1)'(JOB_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_job = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	`LRN_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !full, "job pushed into full queue")
	`LRN_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, !empty, "job popped from empty queue")
	`LRN_ASSERT(a_count_range, clk, arst_n, count_q <= (PTR_W+1)'(JOB_DEPTH), "queue count out of range")
	`LRN_ASSERT_IMP(a_count_up, clk, arst_n, push && !pop, ##1 count_q == $past(count_q) + 1'b1, "count missed a push")
endmodule

// ===== hdl/lrn_front.sv =====
// front part: takes channel requests, keeps the history and counters,
// and queues one job per output that becomes due; depends on lrn_pkg
module lrn_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [lrn_pkg::SAMPLE_W-1:0] s_axis_tdata, // [15:0] sample_value
	input  logic                        s_axis_tlast,
	input  logic [3:0]                  window_size,
	output logic                        job_push,
	output lrn_pkg::lrn_job_t           job_data,
	input  logic                        job_full,
	input  logic                        job_done,
	input  logic [lrn_pkg::HIST_AW-1:0]  hist_raddr,
	output logic [lrn_pkg::SAMPLE_W-1:0] hist_rdata
);
	import lrn_pkg::*;

	front_state_t       state_q, state_d;
	logic [SAMPLE_W-1:0] hist_q [HIST_DEPTH];
	logic [CNT_W-1:0]   arr_q, emi_q;
	logic [CNT_W-1:0]   backlog, backlog_m1;
	logic               last_q, pix_end_q;
	logic [3:0]         win_q, win_eff;
	logic [2:0]         n2_q;
	logic [3:0]         inflight_q;
	logic               accept, stop_emit;

	// effective window: zero acts as one, clamp at the maximum
	always_comb begin
		win_eff = (window_size == 4'd0) ? 4'd1 : window_size;
		if (win_eff > 4'(MAX_WINDOW)) win_eff = 4'(MAX_WINDOW);
	end

	assign accept     = s_axis_tvalid && s_axis_tready;
	assign backlog    = arr_q - emi_q;
	assign backlog_m1 = backlog - 1'b1;
	assign stop_emit  = (backlog == '0) || (!last_q && backlog <= CNT_W'(n2_q));
	assign hist_rdata = hist_q[hist_raddr];

	// job for the oldest pending channel
	always_comb begin
		job_data.slot  = emi_q[HIST_AW-1:0];
		job_data.below = (emi_q < CNT_W'(n2_q)) ? emi_q[2:0] : n2_q;
		job_data.above = (backlog_m1 < CNT_W'(n2_q)) ? backlog_m1[2:0] : n2_q;
		job_data.win   = win_q;
		job_data.last  = last_q && (backlog == CNT_W'(1));
	end

	// next state and handshake
	always_comb begin
		state_d       = state_q;
		job_push      = 1'b0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				// older windows must be read before their slots are reused
				s_axis_tready = (inflight_q == 4'd0) ||
					((inflight_q == 4'd1) && !pix_end_q);
				if (accept) state_d = F_EMIT;
			end
			F_EMIT: begin
				if (stop_emit) state_d = F_IDLE;
				else job_push = !job_full;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= F_IDLE;
		else state_q <= state_d;
	end

	// history write
	always_ff @(posedge clk) begin
		if (accept) hist_q[arr_q[HIST_AW-1:0]] <= s_axis_tdata;
	end

	// counters and per-request settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arr_q      <= '0;
			emi_q      <= '0;
			last_q     <= 1'b0;
			pix_end_q  <= 1'b0;
			win_q      <= 4'd1;
			n2_q       <= '0;
			inflight_q <= '0;
		end else begin
			if (accept) begin
				arr_q     <= arr_q + 1'b1;
				last_q    <= s_axis_tlast;
				pix_end_q <= s_axis_tlast;
				win_q     <= win_eff;
				n2_q      <= win_eff[3:1];
			end
			if (job_push) emi_q <= emi_q + 1'b1;
			if (state_q == F_EMIT && stop_emit && last_q) begin
				arr_q <= '0;
				emi_q <= '0;
			end
			if (job_push && !job_done) inflight_q <= inflight_q + 1'b1;
			else if (job_done && !job_push) inflight_q <= inflight_q - 1'b1;
		end
	end
endmodule

// ===== hdl/lrn_back.sv =====
// back part: window sum of squares, log2 / scale / exp2 sequencer and
// output register; depends on lrn_pkg
module lrn_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_empty,
	input  lrn_pkg::lrn_job_t           job_data,
	output logic                        job_pop,
	output logic                        job_done,
	output logic [lrn_pkg::HIST_AW-1:0]  hist_raddr,
	input  logic [lrn_pkg::SAMPLE_W-1:0] hist_rdata,
	input  logic [31:0]                 alpha_scale,
	input  logic [15:0]                 beta_power,
	input  logic [23:0]                 bias_k,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [lrn_pkg::SAMPLE_W-1:0] m_axis_tdata, // [15:0] normalized_value
	output logic                        m_axis_tlast
);
	import lrn_pkg::*;

	localparam logic signed [57:0] Y_LIM = $signed({6'd0, 6'd17, 46'd0});
	localparam logic signed [40:0] L_OFF = $signed({3'd0, 6'd56, 32'd0});

	back_state_t         state_q, state_d;
	lrn_job_t            job_q;
	logic [3:0]          t_q, span_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] raw_q, res_q;
	logic [65:0]         acc_q;
	logic [NUM_W-1:0]    nx_q;
	logic [6:0]          p_q;
	logic [31:0]         m_q, frac_q, pw_q;
	logic [4:0]          cnt_q;
	logic                logn_q;
	logic [38:0]         lbig_q;
	logic signed [40:0]  l_q;
	logic signed [57:0]  y_q;
	logic [5:0]          yi_q;
	logic [30:0]         fb_q;
	logic [47:0]         val_q;
	logic                out_valid_q, out_last_q;
	logic [SAMPLE_W-1:0] out_data_q;

	logic [SAMPLE_W-1:0] vmag, raw_mag, lim;
	logic                raw_neg, out_free;
	logic [31:0]         sq;
	logic [33:0]         hi_prod;
	logic [27:0]         kn;
	logic [63:0]         msq, pmul;
	logic [32:0]         msh;
	logic [31:0]         frac_nx;
	logic signed [57:0]  lprod, ye;
	logic [5:0]          sh;
	logic [48:0]         rsum, rsh;
	logic [33:0]         rv;
	logic [15:0]         rc;

	assign hist_raddr = job_q.slot - {1'b0, job_q.below} + t_q;
	assign out_free   = !out_valid_q || m_axis_tready;

	// datapath arithmetic
	always_comb begin
		vmag    = hist_rdata[SAMPLE_W-1] ? (SAMPLE_W'(0) - hist_rdata) : hist_rdata;
		sq      = vmag * vmag;
		raw_neg = raw_q[SAMPLE_W-1];
		raw_mag = raw_neg ? (SAMPLE_W'(0) - raw_q) : raw_q;
		lim     = raw_neg ? 16'h8000 : 16'h7fff;
		hi_prod = {2'b0, alpha_scale} * {32'b0, sum_q[33:32]};
		kn      = {4'b0, bias_k} * {24'b0, job_q.win};
		msq     = m_q * m_q;
		msh     = msq[63:31];
		frac_nx = {frac_q[30:0], msh[32]};
		lprod   = l_q * $signed({1'b0, beta_power});
		ye      = y_q + Y_LIM;
		pmul    = pw_q * EXP2_ROOT[cnt_q];
		sh      = 6'd48 - yi_q;
		rsum    = {1'b0, val_q} + (49'd1 << (sh - 6'd1));
		rsh     = rsum >> sh;
		rv      = rsh[33:0];
		rc      = (rv > {18'd0, lim}) ? lim : rv[15:0];
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		job_pop  = 1'b0;
		job_done = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				job_pop = !job_empty;
				if (!job_empty) state_d = B_SUM;
			end
			B_SUM:    if (t_q == span_q) state_d = B_MUL_LO;
			B_MUL_LO: state_d = B_MUL_HI;
			B_MUL_HI: state_d = B_ADDK;
			B_ADDK:   state_d = B_ZERO;
			B_ZERO:   state_d = (nx_q == '0) ? B_OUT : B_NORM;
			B_NORM:   if (nx_q[NUM_W-1]) state_d = B_LOG;
			B_LOG:    if (cnt_q == 5'd31) state_d = logn_q ? B_DIFF : B_NORM;
			B_DIFF:   state_d = B_POW;
			B_POW:    state_d = B_SEL;
			B_SEL: begin
				if (raw_mag == '0 || y_q <= -Y_LIM || y_q >= Y_LIM) state_d = B_OUT;
				else state_d = B_EXP;
			end
			B_EXP:    if (cnt_q == 5'd31) state_d = B_SCALE;
			B_SCALE:  state_d = B_ROUND;
			B_ROUND:  state_d = B_OUT;
			B_OUT: begin
				job_done = out_free;
				if (out_free) state_d = B_IDLE;
			end
			default:  state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= B_IDLE;
		else state_q <= state_d;
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				job_q  <= job_data;
				t_q    <= '0;
				sum_q  <= '0;
				span_q <= {1'b0, job_data.below} + {1'b0, job_data.above};
			end
			B_SUM: begin
				sum_q <= sum_q + SUM_W'(sq);
				if (t_q == {1'b0, job_q.below}) raw_q <= hist_rdata;
				t_q <= t_q + 1'b1;
			end
			B_MUL_LO: acc_q <= 66'(alpha_scale * sum_q[31:0]);
			B_MUL_HI: acc_q <= acc_q + {hi_prod, 32'b0};
			B_ADDK: begin
				nx_q   <= {1'b0, acc_q} + {1'b0, kn, 40'b0};
				p_q    <= 7'd68;
				logn_q <= 1'b0;
			end
			B_ZERO: res_q <= (beta_power == '0) ? raw_q : '0;
			// bring the leading one to the top, a byte at a time where possible
			B_NORM: begin
				if (nx_q[NUM_W-1]) begin
					m_q    <= nx_q[NUM_W-1 -: 32];
					frac_q <= '0;
					cnt_q  <= '0;
				end else if (nx_q[NUM_W-1 -: 8] == 8'd0) begin
					nx_q <= nx_q << 8;
					p_q  <= p_q - 7'd8;
				end else begin
					nx_q <= nx_q << 1;
					p_q  <= p_q - 7'd1;
				end
			end
			// one fraction bit of log2 per squaring
			B_LOG: begin
				m_q    <= msh[32] ? msh[32:1] : msh[31:0];
				frac_q <= frac_nx;
				cnt_q  <= cnt_q + 1'b1;
				if (cnt_q == 5'd31 && !logn_q) begin
					lbig_q <= {p_q, frac_nx};
					nx_q   <= {job_q.win, 65'b0};
					p_q    <= 7'd3;
					logn_q <= 1'b1;
				end
			end
			B_DIFF: l_q <= $signed({2'b0, lbig_q}) - $signed({2'b0, p_q, frac_q}) - L_OFF;
			B_POW:  y_q <= -lprod;
			B_SEL: begin
				if (raw_mag == '0 || y_q <= -Y_LIM) res_q <= '0;
				else if (y_q >= Y_LIM) res_q <= lim;
				yi_q  <= ye[51:46];
				fb_q  <= ye[45:15];
				pw_q  <= 32'h8000_0000;
				cnt_q <= 5'd1;
			end
			// multiply in the root for each set fraction bit
			B_EXP: begin
				if (fb_q[5'd31 - cnt_q]) pw_q <= pmul[62:31];
				cnt_q <= cnt_q + 1'b1;
			end
			B_SCALE: val_q <= {32'b0, raw_mag} * {16'b0, pw_q};
			B_ROUND: res_q <= raw_neg ? (16'd0 - rc) : rc;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (job_done) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_done) begin
			out_data_q <= res_q;
			out_last_q <= job_q.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
endmodule

// ===== hdl/local_response_normalization_core.sv =====
// top level of the cross-channel local response normalization core
// depends on lrn_pkg, lrn_front, lrn_job_fifo, lrn_back
//
// channel   direction  payload
// s_axis    in         tdata[15:0] sample_value, tlast last_in
// m_axis    out        tdata[15:0] normalized_value, tlast last_out
// cfg       in         cfg_addr register index, cfg_wdata value
//
// a result is built by the back part: a window sum of squares over 1 to 15 samples, two 32-step log2
// loops and a 31-step exp2 loop; a saturating result skips the exp2 loop, a zero denominator skips all loops
// a request is taken in idle once no job is in flight, or one is and the last request did not end a pixel;
// then its due jobs are queued; reset is asynchronous, active low, and restores the default registers
// a stalled output holds the back part; a new pixel waits for the old one
module local_response_normalization_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [lrn_pkg::SAMPLE_W-1:0] s_axis_tdata, // [15:0] sample_value
	input  logic                        s_axis_tlast,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [lrn_pkg::SAMPLE_W-1:0] m_axis_tdata, // [15:0] normalized_value
	output logic                        m_axis_tlast,
	input  logic                        cfg_we,
	input  logic [lrn_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [lrn_pkg::CFG_DW-1:0]   cfg_wdata
);
	import lrn_pkg::*;

	logic [3:0]  window_q;
	logic [31:0] alpha_q;
	logic [15:0] beta_q;
	logic [23:0] bias_q;

	logic                job_push, job_full, job_pop, job_empty, job_done;
	lrn_job_t            push_job, pop_job;
	logic [HIST_AW-1:0]  hist_raddr;
	logic [SAMPLE_W-1:0] hist_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RST;
			alpha_q  <= ALPHA_RST;
			beta_q   <= BETA_RST;
			bias_q   <= BIAS_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_WINDOW: window_q <= cfg_wdata[3:0];
				REG_ALPHA:  alpha_q  <= cfg_wdata[31:0];
				REG_BETA:   beta_q   <= cfg_wdata[15:0];
				REG_BIAS:   bias_q   <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	lrn_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.window_size   (window_q),
		.job_push      (job_push),
		.job_data      (push_job),
		.job_full      (job_full),
		.job_done      (job_done),
		.hist_raddr    (hist_raddr),
		.hist_rdata    (hist_rdata)
	);

	lrn_job_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (push_job),
		.full     (job_full),
		.pop      (job_pop),
		.pop_job  (pop_job),
		.empty    (job_empty)
	);

	lrn_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_empty     (job_empty),
		.job_data      (pop_job),
		.job_pop       (job_pop),
		.job_done      (job_done),
		.hist_raddr    (hist_raddr),
		.hist_rdata    (hist_rdata),
		.alpha_scale   (alpha_q),
		.beta_power    (beta_q),
		.bias_k        (bias_q),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);
endmodule
